FILE: hw/rtl/sync_length_packet_deframer_defines.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define SLPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define SLPD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/slpd_pkg.sv
// Package for the sync/length packet deframer: buffer sizing and register codes.
// No dependencies.
package slpd_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // cap on the effective length limit
    localparam logic [6:0] LIM_CAP = 7'(BUF_DEPTH);

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAB;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hCD;
    localparam logic [6:0] LEN_LIMIT_RST   = 7'd60;

    typedef enum logic [1:0] {
        REG_SYNC_FIRST  = 2'd0,
        REG_SYNC_SECOND = 2'd1,
        REG_LEN_LIMIT   = 2'd2,
        REG_NONE        = 2'd3
    } reg_idx_t;

endpackage

FILE: hw/rtl/sync_length_packet_deframer.sv
// Top level: two-byte sync, length-prefixed packet deframer with a payload RAM.
// Depends on slpd_pkg, slpd_ram and sync_length_packet_deframer_defines.svh.
// Throughput: one rx byte per cycle while hunting and collecting; input stalls for a burst.
// Read-out: each byte is read from the RAM, then registered at the output, one per cycle
// while the output is not held off; input stays stalled until the last byte is loaded.
// Reset: async active low; registers to defaults, hunting, error clear; RAM not cleared.
`include "sync_length_packet_deframer_defines.svh"

module sync_length_packet_deframer
    import slpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // receive byte channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // payload result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic [5:0] byte_index,
    output logic       last_byte,
    output logic       error_seen
);

    typedef enum logic [2:0] {
        ST_IDLE,     // hunting first sync byte
        ST_SYNC1,    // first sync seen, expecting second
        ST_SYNC2,    // expecting length byte
        ST_PAYLOAD,  // collecting payload into RAM
        ST_EMIT      // reading the payload back out as a burst
    } state_t;

    // configuration registers
    logic [7:0] sync_first_reg, sync_second_reg;
    logic [6:0] len_limit_reg;

    // parser state
    state_t          state_reg, state_next;
    logic [5:0]      exp_len_reg, exp_len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic            err_reg, err_next;

    // burst read-out
    logic [CNT_W-1:0]  burst_len_reg, burst_len_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;      // RAM rdata holds an unloaded word
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [5:0] out_idx_reg, out_idx_next;
    logic       out_last_reg, out_last_next;
    logic       out_err_reg, out_err_next;

    // RAM port signals
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_rdata;

    logic             accept;
    logic             out_free;
    logic             load;
    logic [6:0]       eff_limit;
    logic [CNT_W-1:0] cnt_inc;

    slpd_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg == ST_EMIT);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign load     = pend_reg && out_free;

    // length byte must be below the smaller of the limit register and the buffer
    assign eff_limit = (len_limit_reg > LIM_CAP) ? LIM_CAP : len_limit_reg;
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign ram_waddr = cnt_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        exp_len_next   = exp_len_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        burst_len_next = burst_len_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        // output register: take a fetched word when free, drop a delivered one
        out_byte_next  = out_byte_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = ram_rdata;
            out_idx_next   = 6'(pend_idx_reg);
            out_last_next  = ((CNT_W'(pend_idx_reg) + CNT_W'(1)) == burst_len_reg);
            out_err_next   = err_reg;
            pend_next      = 1'b0;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (rx_byte == sync_first_reg)
                    begin
                        state_next = ST_SYNC1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            ST_SYNC1:
            begin
                if (accept)
                begin
                    if (rx_byte == sync_second_reg)
                    begin
                        state_next = ST_SYNC2;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SYNC2:
            begin
                if (accept)
                begin
                    if (rx_byte < {1'b0, eff_limit})
                    begin
                        exp_len_next = rx_byte[5:0];
                        cnt_next     = '0;
                        state_next   = ST_PAYLOAD;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (accept)
                begin
                    ram_we = 1'b1;
                    // a length of zero still takes one byte
                    if (7'(cnt_inc) < 7'(exp_len_reg))
                    begin
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        burst_len_next = cnt_inc;
                        rd_idx_next    = '0;
                        cnt_next       = '0;
                        exp_len_next   = '0;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                // issue a read when the fetched word has gone or goes this cycle
                if ((rd_idx_reg < burst_len_reg) && (!pend_reg || load))
                begin
                    ram_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[ADDR_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
                else if ((rd_idx_reg == burst_len_reg) && !pend_next)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            len_limit_reg   <= LEN_LIMIT_RST;
            state_reg       <= ST_IDLE;
            exp_len_reg     <= '0;
            cnt_reg         <= '0;
            err_reg         <= 1'b0;
            burst_len_reg   <= '0;
            rd_idx_reg      <= '0;
            pend_reg        <= 1'b0;
            pend_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_byte_reg    <= '0;
            out_idx_reg     <= '0;
            out_last_reg    <= 1'b0;
            out_err_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                    REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                    REG_LEN_LIMIT:   len_limit_reg   <= cfg_data[6:0];
                    REG_NONE:        ;
                    default:         ;
                endcase
            end
            state_reg     <= state_next;
            exp_len_reg   <= exp_len_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            burst_len_reg <= burst_len_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_idx_reg   <= out_idx_next;
            out_last_reg  <= out_last_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = out_byte_reg;
    assign byte_index   = out_idx_reg;
    assign last_byte    = out_last_reg;
    assign error_seen   = out_err_reg;

    // error flag is sticky
    `SLPD_ASSERT_NEVER(a_err_sticky, $fell(err_reg), "error flag cleared outside reset")
    // reads stay inside the current packet
    `SLPD_ASSERT(a_rd_in_burst, ram_re |-> (rd_idx_reg < burst_len_reg), "read past burst")
    // no payload write while a burst is read out
    `SLPD_ASSERT_NEVER(a_no_wr_emit, ram_we && (state_reg == ST_EMIT), "write during burst")
    // burst ends only once the last fetched word has been taken
    `SLPD_ASSERT(a_exit_drained,
                 ((state_reg == ST_EMIT) && (state_next == ST_IDLE)) |-> !pend_next,
                 "burst left with word pending")

endmodule

FILE: hw/rtl/slpd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module slpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/sv/tb_sync_length_packet_deframer.sv
// Self-checking testbench for the sync/length packet deframer.
// Depends on slpd_pkg and the sync_length_packet_deframer RTL; includes its own
// behavioural predictor of the deframer.
module tb_sync_length_packet_deframer
    import slpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run limits. The slowest legal run stays far below the cycle limit.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_QUIET = 8;     // first result trails its last byte through state, RAM and output registers
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off to fill the block

    // One payload result as the block presents it
    typedef struct packed {
        logic [7:0] data;
        logic [5:0] idx;
        logic       last;
        logic       err;
    } result_t;

    // Predictor parse phase
    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        HUNT_LENGTH,
        COLLECT
    } hunt_e;

    // How a directed row is checked
    typedef enum logic [1:0] {
        ROW_PRED,   // results from the predictor
        ROW_QUIET,  // no result, typed in
        ROW_ONE     // exactly one result, typed in
    } row_kind_e;

    typedef struct packed {
        logic [7:0] rx;
        row_kind_e  kind;
        result_t    want;
    } drow_t;

    localparam result_t NO_RES = '0;

    // Directed stimulus, all at reset register values (0xAB, 0xCD, limit 60).
    // The sticky error flag is clear only for the first packet.
    localparam drow_t DIRECTED [23] = '{
        '{8'hAB, ROW_QUIET, NO_RES},
        '{8'hCD, ROW_QUIET, NO_RES},
        '{8'h00, ROW_QUIET, NO_RES},                      // zero length
        '{8'hFF, ROW_ONE,   '{8'hFF, 6'd0, 1'b1, 1'b0}},  // still one byte collected
        '{8'h12, ROW_QUIET, NO_RES},                      // junk while hunting: error
        '{8'hAB, ROW_QUIET, NO_RES},
        '{8'h00, ROW_QUIET, NO_RES},                      // bad second sync
        '{8'hAB, ROW_QUIET, NO_RES},
        '{8'hCD, ROW_QUIET, NO_RES},
        '{8'h3C, ROW_QUIET, NO_RES},                      // length equal to limit
        '{8'hAB, ROW_QUIET, NO_RES},
        '{8'hCD, ROW_QUIET, NO_RES},
        '{8'h80, ROW_QUIET, NO_RES},                      // top bit set in length
        '{8'hAB, ROW_QUIET, NO_RES},
        '{8'hCD, ROW_QUIET, NO_RES},
        '{8'h01, ROW_QUIET, NO_RES},
        '{8'h00, ROW_ONE,   '{8'h00, 6'd0, 1'b1, 1'b1}},  // flag now stuck high
        '{8'hAB, ROW_QUIET, NO_RES},
        '{8'hCD, ROW_QUIET, NO_RES},
        '{8'h03, ROW_QUIET, NO_RES},
        '{8'h55, ROW_QUIET, NO_RES},
        '{8'hAA, ROW_QUIET, NO_RES},
        '{8'h7F, ROW_PRED,  NO_RES}                       // three-byte burst
    };

    // DUT connections
    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last_byte;
    logic       error_seen;

    // Predictor copy of the registers and parse state
    logic [7:0] m_sync_first;
    logic [7:0] m_sync_second;
    logic [6:0] m_len_limit;
    hunt_e      hunt;
    logic [5:0] pkt_len;
    logic [6:0] rcv_cnt;
    logic [7:0] pay_mem [BUF_DEPTH];
    logic       err_flag;

    result_t    burst_out [$];   // results of the latest accepted byte
    result_t    payload_due [$]; // results still owed by the block

    int mismatches   = 0;
    int cyc          = 0;
    int items_sent   = 0;
    int snd_idle_pct = 19;
    int rcv_idle_pct = 75;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    sync_length_packet_deframer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .last_byte    (last_byte),
        .error_seen   (error_seen)
    );

    always #10 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends here
    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Lengths must be below the limit, capped at the buffer depth
    function automatic int eff_limit();
        int lim;
        lim = int'(m_len_limit);
        return (lim > BUF_DEPTH) ? BUF_DEPTH : lim;
    endfunction

    function automatic void cfg_apply(input reg_idx_t idx, input logic [7:0] d);
        case (idx)
            REG_SYNC_FIRST:  m_sync_first  = d;
            REG_SYNC_SECOND: m_sync_second = d;
            REG_LEN_LIMIT:   m_len_limit   = d[6:0];
            default:         ;  // spare index is ignored
        endcase
    endfunction

    function automatic void deframe_reset();
        m_sync_first  = SYNC_FIRST_RST;
        m_sync_second = SYNC_SECOND_RST;
        m_len_limit   = LEN_LIMIT_RST;
        hunt          = HUNT_FIRST;
        pkt_len       = '0;
        rcv_cnt       = '0;
        err_flag      = 1'b0;
    endfunction

    // Advance the parser by one byte; any completed payload lands in burst_out
    function automatic void deframe_step(input logic [7:0] b);
        int      n;
        result_t r;
        burst_out.delete();
        case (hunt)
            HUNT_FIRST:
            begin
                if (b == m_sync_first)
                    hunt = HUNT_SECOND;
                else
                    err_flag = 1'b1;
            end
            HUNT_SECOND:
            begin
                if (b == m_sync_second)
                    hunt = HUNT_LENGTH;
                else
                begin
                    err_flag = 1'b1;
                    hunt     = HUNT_FIRST;
                end
            end
            HUNT_LENGTH:
            begin
                if (int'(b) < eff_limit())
                begin
                    pkt_len = b[5:0];
                    rcv_cnt = '0;
                    hunt    = COLLECT;
                end
                else
                begin
                    err_flag = 1'b1;
                    hunt     = HUNT_FIRST;
                end
            end
            default:
            begin
                if (rcv_cnt < 7'(BUF_DEPTH))
                    pay_mem[rcv_cnt[5:0]] = b;
                rcv_cnt = rcv_cnt + 7'd1;
                // a zero length still takes one byte, since the count is 1 here
                if (rcv_cnt >= {1'b0, pkt_len})
                begin
                    n = (int'(rcv_cnt) > BUF_DEPTH) ? BUF_DEPTH : int'(rcv_cnt);
                    for (int k = 0; k < n; k++)
                    begin
                        r.data = pay_mem[k];
                        r.idx  = 6'(k);
                        r.last = (k + 1 == n);
                        r.err  = err_flag;
                        burst_out.push_back(r);
                    end
                    rcv_cnt = '0;
                    pkt_len = '0;
                    hunt    = HUNT_FIRST;
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Receiver: random stall, overridden by the long hold-off when one is asked for
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    // Each result transfer is matched against the oldest owed result
    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (payload_due.size() == 0)
                report("result with nothing owed (payload_byte)", payload_byte, -1);
            else
            begin
                w = payload_due.pop_front();
                if (payload_byte !== w.data)
                    report("payload_byte", payload_byte, w.data);
                if (byte_index !== w.idx)
                    report("byte_index", byte_index, w.idx);
                if (last_byte !== w.last)
                    report("last_byte", last_byte, w.last);
                if (error_seen !== w.err)
                    report("error_seen", error_seen, w.err);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    // Offer one byte and hold it until the transfer. Returns at the transfer
    // edge with valid still high, so the caller either offers the next byte
    // or drops valid in the same step.
    task automatic send_byte(input logic [7:0] b, input bit predict);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        deframe_step(b);
        if (predict)
            foreach (burst_out[k])
                payload_due.push_back(burst_out[k]);
    endtask

    // Stop offering and let every owed result come out, plus the burst tail
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (payload_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_QUIET) @(posedge clk);
    endtask

    // Write the three registers, and optionally the spare index as well.
    // Only called with the block idle.
    task automatic load_regs(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] lim, input bit poke_spare);
        reg_idx_t   idx [4];
        logic [7:0] val [4];
        int         nw;
        idx = '{REG_SYNC_FIRST, REG_SYNC_SECOND, REG_LEN_LIMIT, REG_NONE};
        val = '{s1, s2, lim, 8'($urandom_range(0, 255))};
        nw  = poke_spare ? 4 : 3;
        for (int i = 0; i < nw; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            cfg_apply(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // One random frame: mostly well formed with random payload and mostly
    // short lengths; the rest is line noise, a bad second sync or an
    // oversized length.
    task automatic send_frame(input bit go_long);
        int eff;
        int pick;
        int len;
        int cap;
        eff  = eff_limit();
        pick = go_long ? 99 : $urandom_range(0, 99);
        if (pick < 8)
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        else
        begin
            send_byte(m_sync_first, 1'b1);
            if (pick < 13)
                send_byte(m_sync_second ^ 8'($urandom_range(1, 255)), 1'b1);
            else
            begin
                send_byte(m_sync_second, 1'b1);
                if (pick < 18 || eff == 0)
                    send_byte(8'($urandom_range(eff, 255)), 1'b1);
                else
                begin
                    cap = (eff - 1 < 7) ? eff - 1 : 7;
                    case ($urandom_range(0, 9))
                        0:       len = 0;
                        1:       len = eff - 1;
                        default: len = $urandom_range(0, cap);
                    endcase
                    if (go_long)
                        len = eff - 1;
                    send_byte(8'(len), 1'b1);
                    for (int k = 0; k < ((len == 0) ? 1 : len); k++)
                        send_byte(8'($urandom_range(0, 255)), 1'b1);
                end
            end
        end
    endtask

    // One settings phase: drain, set idling, write registers, then frames
    task automatic run_phase(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] lim, input bit poke_spare,
                             input int snd_pct, input int rcv_pct, input int n_items,
                             input bit mid_pause, input bit squeeze);
        int start;
        wait_drained();
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        load_regs(s1, s2, lim, poke_spare);
        start = items_sent;
        if (squeeze)
        begin
            // receiver holds off while the sender keeps offering, so the
            // block fills with a burst and stalls its input
            hold_req <= hold_req + 1;
            send_frame(1'b1);
        end
        while (items_sent - start < n_items)
        begin
            send_frame(1'b0);
            if (mid_pause && items_sent - start >= n_items / 2)
            begin
                mid_pause = 1'b0;
                wait_drained();
            end
        end
    endtask

    initial
    begin
        // every input known from time zero, reset held low at the start
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SYNC_FIRST;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        out_stall = 1'b0;
        deframe_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows at reset register values; sender 19 %, receiver 75 %
        foreach (DIRECTED[i])
        begin
            send_byte(DIRECTED[i].rx, DIRECTED[i].kind == ROW_PRED);
            if (DIRECTED[i].kind == ROW_ONE)
                payload_due.push_back(DIRECTED[i].want);
        end

        // random sync values, limit right at the buffer depth
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'(BUF_DEPTH), 1'b0, 19, 75, 100, 1'b1, 1'b0);
        // idling swapped: extreme sync values, limit well above the buffer
        run_phase(8'h00, 8'hFF, 8'hFF, 1'b0, 75, 19, 90, 1'b0, 1'b0);
        // limit of one: only zero-length frames get through
        run_phase(8'hFF, 8'h00, 8'd1, 1'b0, 75, 19, 50, 1'b0, 1'b0);
        // no idling: limit of zero via the masked top bit, spare index poked
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'h80, 1'b1, 0, 0, 40, 1'b0, 1'b0);
        // reset sync values, random large limit, long hold-off at the start
        run_phase(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'($urandom_range(33, 64)),
                  1'b0, 0, 0, 120, 1'b0, 1'b1);

        wait_drained();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
